// File: hdl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define FRC_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("frc assertion failed");

// next-cycle implication, disabled while reset is low
`define FRC_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("frc assertion failed");

`endif

// File: hdl/frc_pkg.sv
// types and constants of the frame redness change detector
// no dependencies
package frc_pkg;

  localparam int unsigned MaxFramePixels = 1048576;
  localparam int unsigned ColorW         = 8;
  localparam int unsigned PixSumW        = ColorW + 2;
  localparam int unsigned SumW           = 28;
  localparam int unsigned FracW          = 16;
  localparam int unsigned RednessW       = 18;
  localparam int unsigned ThreshW        = 16;
  localparam int unsigned NumW           = SumW + FracW;
  localparam int unsigned DenW           = SumW + 2;
  localparam int unsigned DivSteps       = NumW;
  localparam int unsigned CntW           = $clog2(DivSteps);
  // floor(x/3) = (x*683) >> 11 for every x below 2048
  localparam int unsigned Recip3W        = 10;
  localparam int unsigned Recip3Shift    = 11;
  localparam int unsigned ProdW          = PixSumW + Recip3W;

  localparam logic [Recip3W-1:0]  Recip3       = 10'd683;
  localparam logic [SumW-1:0]     SumMax       = {SumW{1'b1}};
  localparam logic [RednessW-1:0] RednessMax   = {RednessW{1'b1}};
  localparam logic [ThreshW-1:0]  ThreshReset  = 16'd328;
  localparam logic [CntW-1:0]     DivLastCount = CntW'(DivSteps - 1);

  typedef enum logic [1:0] {
    S_ACCUM,
    S_DIV,
    S_DONE
  } frc_state_e;

  typedef struct packed {
    logic accum;   // pixel word taken this cycle
    logic start;   // frame-end pixel: load divider, clear sums
    logic step;    // one division step
    logic finish;  // write result, update average
  } frc_cmd_t;

  typedef struct packed {
    logic out_free;  // output register can take a word this cycle
  } frc_status_t;

endpackage

// File: hdl/frc_ifs.sv
// valid/ready stream interfaces for pixels and frame results
// depends on frc_pkg
interface frc_pixel_if
  import frc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ColorW-1:0] red;
  logic [ColorW-1:0] green;
  logic [ColorW-1:0] blue;
  logic              last_in_frame;

  modport source (output valid, red, green, blue, last_in_frame, input ready);
  modport sink   (input valid, red, green, blue, last_in_frame, output ready);
endinterface

interface frc_result_if
  import frc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                object_missing;
  logic [RednessW-1:0] frame_redness;
  logic                zero_intensity;

  modport source (output valid, object_missing, frame_redness, zero_intensity,
                  input ready);
  modport sink   (input valid, object_missing, frame_redness, zero_intensity,
                  output ready);
endinterface

// File: hdl/frc_ctrl.sv
// controller: pixel accumulation, division sequencing, result hand-off
// depends on frc_pkg
module frc_ctrl
  import frc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_last_i,
  output logic        in_ready_o,
  input  frc_status_t status_i,
  output frc_cmd_t    cmd_o
);

  frc_state_e      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            in_fire;

  assign in_ready_o = (state_q == S_ACCUM);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_ACCUM: begin
        cnt_d = '0;
        if (in_fire && in_last_i) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivLastCount) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          state_d = S_ACCUM;
        end
      end
      default: begin
        state_d = S_ACCUM;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_ACCUM: begin
        cmd_o.accum = in_fire;
        cmd_o.start = in_fire && in_last_i;
      end
      S_DIV: begin
        cmd_o.step = 1'b1;
      end
      S_DONE: begin
        cmd_o.finish = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ACCUM;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: hdl/frc_datapath.sv
// datapath: saturating sums, restoring divider, average compare, output register
// depends on frc_pkg
module frc_datapath
  import frc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  frc_cmd_t            cmd_i,
  output frc_status_t         status_o,
  input  logic [ColorW-1:0]   red_i,
  input  logic [ColorW-1:0]   green_i,
  input  logic [ColorW-1:0]   blue_i,
  input  logic                cfg_we_i,
  input  logic [ThreshW-1:0]  cfg_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic                object_missing_o,
  output logic [RednessW-1:0] frame_redness_o,
  output logic                zero_intensity_o
);

  logic [ThreshW-1:0]  thr_q;
  logic [SumW-1:0]     red_total_q, intensity_total_q;
  logic [RednessW-1:0] avg_q, avg_d;
  logic                seen_q;

  logic [NumW-1:0]     num_q;
  logic [DenW-1:0]     den_q, rem_q;
  logic [RednessW-1:0] quo_q;
  logic                ovf_q;
  logic                zero_q;

  logic                out_valid_q;
  logic                missing_q;
  logic [RednessW-1:0] redness_q;
  logic                zero_out_q;

  // per-pixel sums
  logic [PixSumW-1:0]  pix_sum;
  logic [ProdW-1:0]    pix_prod;
  logic [ColorW-1:0]   pix_third;
  logic [SumW:0]       red_ext, int_ext;
  logic [SumW-1:0]     red_sum, int_sum;
  logic [DenW-1:0]     den_new;

  assign pix_sum   = PixSumW'(red_i) + PixSumW'(green_i) + PixSumW'(blue_i);
  assign pix_prod  = ProdW'(pix_sum) * ProdW'(Recip3);
  assign pix_third = pix_prod[Recip3Shift +: ColorW];

  assign red_ext = {1'b0, red_total_q} + (SumW+1)'(red_i);
  assign int_ext = {1'b0, intensity_total_q} + (SumW+1)'(pix_third);
  assign red_sum = red_ext[SumW] ? SumMax : red_ext[SumW-1:0];
  assign int_sum = int_ext[SumW] ? SumMax : int_ext[SumW-1:0];
  assign den_new = DenW'(int_sum) + DenW'({int_sum, 1'b0});

  // one restoring division step
  logic [DenW:0]   trial;
  logic            q_bit;
  logic [DenW-1:0] rem_next;

  assign trial    = {rem_q, num_q[NumW-1]};
  assign q_bit    = (trial >= {1'b0, den_q});
  assign rem_next = q_bit ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];

  // frame-end compare against the running average
  logic [RednessW-1:0] redness;
  logic [RednessW-1:0] diff;
  logic [RednessW:0]   avg_sum;
  logic                missing;

  assign redness = ovf_q ? RednessMax : quo_q;
  assign diff    = (avg_q > redness) ? (avg_q - redness) : (redness - avg_q);
  assign missing = seen_q && (diff > RednessW'(thr_q));
  assign avg_sum = {1'b0, avg_q} + {1'b0, redness};

  always_comb begin
    avg_d = avg_q;
    if (!seen_q) begin
      avg_d = redness;
    end else if (!missing) begin
      avg_d = avg_sum[RednessW:1];
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q             <= ThreshReset;
      red_total_q       <= '0;
      intensity_total_q <= '0;
      avg_q             <= '0;
      seen_q            <= 1'b0;
      out_valid_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_data_i;
      end
      if (cmd_i.start) begin
        red_total_q       <= '0;
        intensity_total_q <= '0;
      end else if (cmd_i.accum) begin
        red_total_q       <= red_sum;
        intensity_total_q <= int_sum;
      end
      if (cmd_i.finish) begin
        avg_q       <= avg_d;
        seen_q      <= 1'b1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      num_q  <= {red_sum, {FracW{1'b0}}};
      den_q  <= den_new;
      rem_q  <= '0;
      quo_q  <= '0;
      ovf_q  <= 1'b0;
      zero_q <= (int_sum == '0);
    end else if (cmd_i.step) begin
      num_q <= {num_q[NumW-2:0], 1'b0};
      rem_q <= rem_next;
      // any quotient bit shifted past the top saturates the result
      ovf_q <= ovf_q | quo_q[RednessW-1];
      quo_q <= {quo_q[RednessW-2:0], q_bit};
    end
    if (cmd_i.finish) begin
      missing_q  <= missing;
      redness_q  <= redness;
      zero_out_q <= zero_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign object_missing_o = missing_q;
  assign frame_redness_o  = redness_q;
  assign zero_intensity_o = zero_out_q;

endmodule

// File: hdl/frame_redness_change_detector.sv
// top level of the frame redness change detector
// depends on frc_pkg, frc_ifs, frc_ctrl, frc_datapath
//
//   port        dir   kind        contents
//   pixel_i     in    stream      red, green, blue, last_in_frame
//   result_o    out   stream      object_missing, frame_redness, zero_intensity
//   cfg_we_i    in    write       difference_threshold (cfg_data_i, 16 bits)
//
// ordinary pixels: one word per cycle.
// frame-end pixel: the bit-serial restoring divider runs, then the result is
//   compared and written; pixel input is stalled meanwhile.
// a result not yet taken holds off the finish cycle, and pixel input stays
//   stalled until the output side takes it.
// reset clears sums, average and first-frame flag and sets the threshold (328) at once.
module frame_redness_change_detector
  import frc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  frc_pixel_if.sink          pixel_i,
  frc_result_if.source       result_o,
  input  logic               cfg_we_i,
  input  logic [ThreshW-1:0] cfg_data_i
);

  frc_cmd_t    cmd;
  frc_status_t status;

  frc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pixel_i.valid),
    .in_last_i  (pixel_i.last_in_frame),
    .in_ready_o (pixel_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  frc_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .red_i            (pixel_i.red),
    .green_i          (pixel_i.green),
    .blue_i           (pixel_i.blue),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .out_ready_i      (result_o.ready),
    .out_valid_o      (result_o.valid),
    .object_missing_o (result_o.object_missing),
    .frame_redness_o  (result_o.frame_redness),
    .zero_intensity_o (result_o.zero_intensity)
  );

endmodule

// File: hdl/frc_checker.sv
// port-level checks for the frame redness change detector, bound to the top
// depends on frc_pkg and assert_macros.svh
`include "assert_macros.svh"

module frc_checker
  import frc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                pix_valid_i,
  input logic                pix_ready_i,
  input logic                pix_last_i,
  input logic                res_valid_i,
  input logic                res_ready_i,
  input logic                res_missing_i,
  input logic [RednessW-1:0] res_redness_i,
  input logic                res_zero_i
);

  // a held result word stays up
  `FRC_ASSERT_NXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i)

  // a held result word keeps its payload
  `FRC_ASSERT_NXT(a_res_stable, clk_i, rst_ni, res_valid_i && !res_ready_i,
    $stable(res_redness_i) && $stable(res_missing_i) && $stable(res_zero_i))

  // frame end starts the divider, so pixel input stops next cycle
  `FRC_ASSERT_NXT(a_div_stall, clk_i, rst_ni, pix_valid_i && pix_ready_i && pix_last_i,
    !pix_ready_i)

  // a frame with zero intensity always reports saturated redness
  `FRC_ASSERT_IMP(a_zero_sat, clk_i, rst_ni, res_valid_i && res_zero_i,
    res_redness_i == RednessMax)

endmodule

bind frame_redness_change_detector frc_checker u_frc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .pix_valid_i   (pixel_i.valid),
  .pix_ready_i   (pixel_i.ready),
  .pix_last_i    (pixel_i.last_in_frame),
  .res_valid_i   (result_o.valid),
  .res_ready_i   (result_o.ready),
  .res_missing_i (result_o.object_missing),
  .res_redness_i (result_o.frame_redness),
  .res_zero_i    (result_o.zero_intensity)
);
